[design/bba_pkg.sv]
// Package for the block bitmap allocator: map geometry, command codes and widths.
// Used by the channel interfaces and by block_bitmap_allocator.
package bba_pkg;

  // map geometry
  localparam int NUM_BLOCKS = 1024;
  localparam int WORD_LG    = 6;
  localparam int WORD_W     = 1 << WORD_LG;
  localparam int NUM_WORDS  = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int WADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int FULL_W     = WADDR_W + WORD_LG;
  localparam int BLK_REM    = NUM_BLOCKS % WORD_W;

  // field widths
  localparam int CMD_W = 2;
  localparam int IDX_W = 10;
  localparam int FDB_W = 11;
  localparam int CMP_W = (FULL_W >= FDB_W) ? FULL_W + 1 : FDB_W + 1;

  // last map word, and which of its bits are real blocks
  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NUM_WORDS - 1);
  localparam logic [WORD_W-1:0]  LAST_MASK = (BLK_REM == 0) ? {WORD_W{1'b1}} :
                                             ((WORD_W'(1) << BLK_REM) - WORD_W'(1));

  // command codes
  localparam logic [CMD_W-1:0] CMD_INIT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FIND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MARK = 2'd2;

endpackage

[design/bba_if.sv]
// Valid/ready channel interfaces for the block bitmap allocator.
// Depends on bba_pkg for the field widths.

// request channel: command, block index, used flag
interface bba_req_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [IDX_W-1:0] block_index;
  logic             used_flag;

  modport source (output valid, output cmd, output block_index, output used_flag,
                  input ready);
  modport sink   (input valid, input cmd, input block_index, input used_flag,
                  output ready);
endinterface

// response channel: found flag and located block
interface bba_rsp_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [IDX_W-1:0] free_index;

  modport source (output valid, output found, output free_index, input ready);
  modport sink   (input valid, input found, input free_index, output ready);
endinterface

[design/block_bitmap_allocator.sv]
// Free-block bitmap allocator with first-fit search over a word-wide map memory.
// Depends on bba_pkg and the channel interfaces in bba_if.sv.
//
//  channel      dir  handshake     contents
//  req_i        in   valid/ready   cmd, block_index, used_flag
//  rsp_o        out  valid/ready   found, free_index
//  cfg_we_i     in   write enable  cfg_data_i = index of the first data block
//
//  Find reads one 64-bit map word per cycle through the single read port and
//  priority-encodes it, then a response state follows. Mark is a read-modify-write
//  of one word. Initialise writes every word once. req_i.ready is high only between
//  requests. Reset clears per-word valid bits, so the whole map reads free at once.
//  A request is taken while an earlier response still waits in the output register.
module block_bitmap_allocator import bba_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [FDB_W-1:0] cfg_data_i,
  bba_req_if.sink          req_i,
  bba_rsp_if.source        rsp_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_MARK = 3'd2;
  localparam logic [2:0] ST_INIT = 3'd3;
  localparam logic [2:0] ST_RESP = 3'd4;

  // lowest set bit of a map word
  function automatic logic [WORD_LG-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [WORD_LG-1:0] p;
    p = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) p = WORD_LG'(i);
    end
    return p;
  endfunction

  logic [2:0]         state_q, state_d;
  logic [FDB_W-1:0]   fdb_q;
  logic [WADDR_W-1:0] addr_q, addr_d;
  logic [WORD_LG-1:0] off_q, off_d;
  logic               first_q, first_d;
  logic               flag_q, flag_d;
  logic [IDX_W-1:0]   start_q, start_d;
  logic               res_found_q, res_found_d;
  logic [IDX_W-1:0]   res_idx_q, res_idx_d;
  logic               out_valid_q;
  logic               found_q;
  logic [IDX_W-1:0]   free_idx_q;

  // map memory with per-word valid bits
  logic [WORD_W-1:0]    mem_q [NUM_WORDS];
  logic [NUM_WORDS-1:0] wvalid_q;
  logic [WORD_W-1:0]    rdata_q;
  logic                 rvld_q;
  logic [WADDR_W-1:0]   rd_addr;
  logic                 wr_en;
  logic [WADDR_W-1:0]   wr_addr;
  logic [WORD_W-1:0]    wr_data;

  logic               req_fire;
  logic               in_range;
  logic [WADDR_W-1:0] req_word;
  logic [WORD_W-1:0]  word, cand, smask, lmask;
  logic               hit, at_last, rsp_free;
  logic [WORD_LG-1:0] hit_pos;
  logic [FULL_W-1:0]  hit_full;
  logic [CMP_W-1:0]   base, fdb_ext, span;
  logic [WORD_W-1:0]  init_word, bit_sel;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign in_range    = (32'(req_i.block_index) < NUM_BLOCKS);
  assign req_word    = WADDR_W'(req_i.block_index >> WORD_LG);
  assign rsp_free    = !out_valid_q || rsp_o.ready;

  // scan datapath: mask the word read last cycle and pick its lowest free bit
  assign word     = rvld_q ? rdata_q : '0;
  assign smask    = first_q ? ({WORD_W{1'b1}} << off_q) : {WORD_W{1'b1}};
  assign at_last  = (addr_q == LAST_WORD);
  assign lmask    = at_last ? LAST_MASK : {WORD_W{1'b1}};
  assign cand     = ~word & smask & lmask;
  assign hit      = |cand;
  assign hit_pos  = lowest_set(cand);
  assign hit_full = {addr_q, hit_pos};

  // initialise word: bits below the first data block are used
  assign base    = CMP_W'({addr_q, {WORD_LG{1'b0}}});
  assign fdb_ext = CMP_W'(fdb_q);
  assign span    = fdb_ext - base;
  always_comb begin
    if (fdb_ext >= base + CMP_W'(WORD_W)) begin
      init_word = {WORD_W{1'b1}};
    end else if (fdb_ext <= base) begin
      init_word = '0;
    end else begin
      init_word = ~({WORD_W{1'b1}} << span[WORD_LG-1:0]);
    end
  end

  assign bit_sel = WORD_W'(1) << off_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    off_d       = off_q;
    first_d     = first_q;
    flag_d      = flag_q;
    start_d     = start_q;
    res_found_d = res_found_q;
    res_idx_d   = res_idx_q;
    rd_addr     = addr_q;
    wr_en       = 1'b0;
    wr_addr     = addr_q;
    wr_data     = init_word;
    unique case (state_q)
      ST_IDLE: begin
        rd_addr = req_word;
        if (req_fire) begin
          res_found_d = 1'b0;
          res_idx_d   = '0;
          addr_d      = req_word;
          off_d       = req_i.block_index[WORD_LG-1:0];
          first_d     = 1'b1;
          flag_d      = req_i.used_flag;
          start_d     = req_i.block_index;
          state_d     = ST_RESP;
          if (req_i.cmd == CMD_INIT) begin
            addr_d  = '0;
            state_d = ST_INIT;
          end else if (req_i.cmd == CMD_FIND && in_range) begin
            state_d = ST_SCAN;
          end else if (req_i.cmd == CMD_MARK && in_range) begin
            state_d = ST_MARK;
          end
        end
      end
      ST_SCAN: begin
        // read the next word ahead while this one is checked
        rd_addr = at_last ? addr_q : addr_q + WADDR_W'(1);
        first_d = 1'b0;
        if (hit) begin
          res_found_d = 1'b1;
          res_idx_d   = IDX_W'(hit_full);
          state_d     = ST_RESP;
        end else if (at_last) begin
          state_d = ST_RESP;
        end else begin
          addr_d = addr_q + WADDR_W'(1);
        end
      end
      ST_MARK: begin
        wr_en   = 1'b1;
        wr_data = flag_q ? (word | bit_sel) : (word & ~bit_sel);
        state_d = ST_RESP;
      end
      ST_INIT: begin
        wr_en = 1'b1;
        if (at_last) begin
          state_d = ST_RESP;
        end else begin
          addr_d = addr_q + WADDR_W'(1);
        end
      end
      ST_RESP: begin
        if (rsp_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fdb_q       <= '0;
      wvalid_q    <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) fdb_q <= cfg_data_i;
      if (wr_en) wvalid_q[wr_addr] <= 1'b1;
      rvld_q <= wvalid_q[rd_addr];
      if (state_q == ST_RESP && rsp_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    addr_q      <= addr_d;
    off_q       <= off_d;
    first_q     <= first_d;
    flag_q      <= flag_d;
    start_q     <= start_d;
    res_found_q <= res_found_d;
    res_idx_q   <= res_idx_d;
    if (state_q == ST_RESP && rsp_free) begin
      found_q    <= res_found_q;
      free_idx_q <= res_idx_q;
    end
  end

  // map memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rdata_q <= mem_q[rd_addr];
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.found      = found_q;
  assign rsp_o.free_index = free_idx_q;

  // a not-found response always carries index zero
  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.found |-> rsp_o.free_index == '0)
    else $error("not-found response with nonzero index");

  // a located block never lies below the search start
  a_hit_above_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN && hit |-> CMP_W'(hit_full) >= CMP_W'(start_q))
    else $error("find hit below its start block");

  // an in-range mark request goes to the write step next
  a_mark_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && req_i.cmd == CMD_MARK && in_range |=> state_q == ST_MARK)
    else $error("mark request skipped its write");

  // no map write while a find scans the memory
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> !wr_en)
    else $error("map write during scan");

endmodule
